// ===== hw/rtl/rgbhsv_pkg.sv =====
// Shared widths, constants and types of the RGB to HSV pixel converter.
package rgbhsv_pkg;

    localparam int CH_W   = 8;
    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int NUM_W  = 15;
    localparam int Q_W    = 7;
    localparam int NSTAGE = Q_W + 2;

    localparam logic [NUM_W-1:0] HUE_SCALE = NUM_W'(60);
    localparam logic [NUM_W-1:0] PCT_SCALE = NUM_W'(100);
    localparam logic [CH_W-1:0]  CH_FULL   = CH_W'(255);

    localparam logic [HUE_W-1:0] OFS_RED   = HUE_W'(360);
    localparam logic [HUE_W-1:0] OFS_GREEN = HUE_W'(120);
    localparam logic [HUE_W-1:0] OFS_BLUE  = HUE_W'(240);

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_hue_sel;

    typedef struct packed {
        t_hue_sel sel;
        logic     neg;
        logic     grey;
        logic     black;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] hnum;
        logic [CH_W-1:0]  diff;
        logic [NUM_W-1:0] snum;
        logic [CH_W-1:0]  mx;
        logic [NUM_W-1:0] vnum;
        t_side            side;
    } t_front;

endpackage

// ===== hw/rtl/rgbhsv_pix_if.sv =====
// Pixel input channel: valid, ready and the three colour channels.
interface rgbhsv_pix_if;
    import rgbhsv_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/rgbhsv_hsv_if.sv =====
// Result output channel: valid, ready, hue, saturation and brightness.
interface rgbhsv_hsv_if;
    import rgbhsv_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== hw/rtl/rgbhsv_front.sv =====
// First stage: maximum, minimum, hue sector and the scaled numerators.
module rgbhsv_front (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rgbhsv_pkg::CH_W-1:0]   i_red,
    input  logic [rgbhsv_pkg::CH_W-1:0]   i_green,
    input  logic [rgbhsv_pkg::CH_W-1:0]   i_blue,
    output rgbhsv_pkg::t_front            o_front
);
    import rgbhsv_pkg::*;

    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] pa;
    logic [CH_W-1:0] pb;
    logic [CH_W-1:0] mag;
    t_front          n_front;
    t_front          r_front;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;

        if (mx == i_red) begin
            n_front.side.sel = SEL_RED;
            pa = i_green;
            pb = i_blue;
        end else if (mx == i_green) begin
            n_front.side.sel = SEL_GREEN;
            pa = i_blue;
            pb = i_red;
        end else begin
            n_front.side.sel = SEL_BLUE;
            pa = i_red;
            pb = i_green;
        end

        n_front.side.neg   = pb > pa;
        mag                = n_front.side.neg ? (pb - pa) : (pa - pb);
        n_front.diff       = mx - mn;
        n_front.mx         = mx;
        n_front.hnum       = NUM_W'(mag) * HUE_SCALE;
        n_front.snum       = NUM_W'(n_front.diff) * PCT_SCALE;
        n_front.vnum       = NUM_W'(mx) * PCT_SCALE;
        n_front.side.grey  = n_front.diff == '0;
        n_front.side.black = mx == '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;
endmodule

// ===== hw/rtl/rgbhsv_div.sv =====
// Pipelined restoring divider giving one quotient bit per stage.
module rgbhsv_div (
    input  logic                          i_clk,
    input  logic [rgbhsv_pkg::Q_W-1:0]    i_en,
    input  logic [rgbhsv_pkg::NUM_W-1:0]  i_num,
    input  logic [rgbhsv_pkg::CH_W-1:0]   i_den,
    output logic [rgbhsv_pkg::Q_W-1:0]    o_quot,
    output logic [rgbhsv_pkg::CH_W-1:0]   o_rem
);
    import rgbhsv_pkg::*;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [CH_W-1:0]  r_den [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic [NUM_W-1:0] n_rem [Q_W];
    logic [CH_W-1:0]  n_den [Q_W];
    logic [Q_W-1:0]   n_q   [Q_W];
    logic [NUM_W-1:0] rem_in [Q_W];
    logic [NUM_W-1:0] shifted [Q_W];

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                rem_in[k] = i_num;
                n_den[k]  = i_den;
                n_q[k]    = '0;
            end else begin
                rem_in[k] = r_rem[k-1];
                n_den[k]  = r_den[k-1];
                n_q[k]    = r_q[k-1];
            end
            shifted[k] = NUM_W'(n_den[k]) << (Q_W - 1 - k);
            n_rem[k]   = rem_in[k];
            if (rem_in[k] >= shifted[k]) begin
                n_rem[k]              = rem_in[k] - shifted[k];
                n_q[k][Q_W - 1 - k]   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_quot = r_q[Q_W-1];
    assign o_rem  = r_rem[Q_W-1][CH_W-1:0];
endmodule

// ===== hw/rtl/rgbhsv_pixel_top.sv =====
// Top level of the RGB to HSV pixel converter: stage control and result stage.
// One pixel enters per clock while the first stage is empty or moving on. Its result is
// offered on the output from the ninth register stage. One stage finds the
// extremes and numerators. Seven divider stages each settle one quotient bit for hue
// and saturation in parallel. Value, a division by the constant 255, is formed by
// shift and add in the first of those stages and carried along. A final stage applies
// the hue sector offset into the output register. Each stage moves on whenever the
// stage after it is empty or moving, so a stalled output only holds the items that
// are already queued behind it and empty stages keep filling.
module rgb_to_hsv_pixel_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhsv_pix_if.sink    i_pix,
    rgbhsv_hsv_if.source  o_hsv
);
    import rgbhsv_pkg::*;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE:0]   en;
    t_front            front;
    t_side             r_side [1:Q_W];
    logic [PCT_W-1:0]  r_vpipe [1:Q_W];
    logic [NUM_W-1:0]  vsum;
    logic [PCT_W-1:0]  n_val;
    logic [Q_W-1:0]    hq;
    logic [CH_W-1:0]   hrem;
    logic [Q_W-1:0]    sq;
    logic [CH_W-1:0]   srem;
    logic [Q_W-1:0]    qc;
    logic [HUE_W-1:0]  n_hue;
    logic [PCT_W-1:0]  n_sat;
    logic [HUE_W-1:0]  r_hue;
    logic [PCT_W-1:0]  r_sat;
    logic [PCT_W-1:0]  r_val;
    t_side             bs;

    always_comb begin
        en[NSTAGE] = o_hsv.ready;
        for (int i = NSTAGE - 1; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_en    (en[0]),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_front (front)
    );

    rgbhsv_div u_div_hue (
        .i_clk  (i_clk),
        .i_en   (en[Q_W:1]),
        .i_num  (front.hnum),
        .i_den  (front.diff),
        .o_quot (hq),
        .o_rem  (hrem)
    );

    rgbhsv_div u_div_sat (
        .i_clk  (i_clk),
        .i_en   (en[Q_W:1]),
        .i_num  (front.snum),
        .i_den  (front.mx),
        .o_quot (sq),
        .o_rem  (srem)
    );

    // Division by 255 of the value numerator, at most 25500, is exact as (x + x/256 + 1) / 256.
    always_comb begin
        vsum  = front.vnum + (front.vnum >> CH_W) + NUM_W'(1);
        n_val = PCT_W'(vsum >> CH_W);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_side[1]  <= front.side;
            r_vpipe[1] <= n_val;
        end
        for (int k = 2; k <= Q_W; k++) begin
            if (en[k]) begin
                r_side[k]  <= r_side[k-1];
                r_vpipe[k] <= r_vpipe[k-1];
            end
        end
    end

    // A negative hue difference is floored, so an inexact quotient grows by one.
    always_comb begin
        bs    = r_side[Q_W];
        qc    = hq + Q_W'(hrem != '0 || srem == '1 && 1'b0);
        n_hue = '0;
        case (bs.sel)
            SEL_RED:   n_hue = bs.neg ? (OFS_RED - HUE_W'(qc)) : HUE_W'(hq);
            SEL_GREEN: n_hue = bs.neg ? (OFS_GREEN - HUE_W'(qc))
                                      : (OFS_GREEN + HUE_W'(hq));
            SEL_BLUE:  n_hue = bs.neg ? (OFS_BLUE - HUE_W'(qc))
                                      : (OFS_BLUE + HUE_W'(hq));
            default:   n_hue = '0;
        endcase
        if (bs.grey) begin
            n_hue = '0;
        end
        n_sat = bs.black ? '0 : PCT_W'(sq);
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTAGE-1]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= r_vpipe[Q_W];
        end
    end

    assign i_pix.ready      = en[0];
    assign o_hsv.valid      = r_vld[NSTAGE-1];
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.brightness = r_val;
endmodule
